// ----- src/match_overlap_resolver_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef MATCH_OVERLAP_RESOLVER_TOP_ASSERT_SVH
`define MATCH_OVERLAP_RESOLVER_TOP_ASSERT_SVH
// Clocked assertion, masked while reset is high.
`define MOR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds across reset.
`define MOR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/mor_pkg.sv -----
// ----------------------------------------------------------------------------
// mor_pkg
// Shared widths, codes, types and helpers of the match overlap resolver.
// ----------------------------------------------------------------------------
package mor_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned POS_BITS  = 32;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS:0]   wide_type;

   // Largest position value; positions saturate here.
   localparam wide_type POS_ONE   = wide_type'(1);
   localparam wide_type POS_LIMIT = (POS_BITS >= WORD_BITS) ?
                                    {1'b0, {WORD_BITS{1'b1}}} :
                                    ((POS_ONE << POS_BITS) - POS_ONE);

   // Item kinds
   localparam logic MODE_MATCH = 1'b0;
   localparam logic MODE_END   = 1'b1;

   // Configuration register map
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = WORD_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LEN  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REV_MODE = 1'b1;
   localparam word_type MIN_LEN_RESET  = word_type'(32);
   localparam logic     REV_MODE_RESET = 1'b1;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      word_type min_len;
      logic     rev_mode;
   } cfg_type;

   typedef struct packed {
      logic     mode;
      word_type dest_pos;
      word_type src_pos;
      word_type match_len;
      wide_type end_pos;
   } item_type;

   typedef struct packed {
      logic     is_final;
      word_type literal_start;
      word_type literal_count;
      word_type write_pos;
      word_type ref_offset;
      word_type extra_length;
      word_type matched_total;
      word_type overlap_total;
   } result_type;

   function automatic word_type sat_add_word(input word_type a, input word_type b);
      wide_type sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WORD_BITS] ? {WORD_BITS{1'b1}} : sum[WORD_BITS-1:0];
   endfunction

endpackage

// ----- src/mor_if.sv -----
// ----------------------------------------------------------------------------
// mor_if
// Valid/ready channels for match beats and result beats.
// ----------------------------------------------------------------------------
interface mor_req_if;
   import mor_pkg::*;
   logic     valid;
   logic     ready;
   logic     mode;
   word_type dest_pos;
   word_type src_pos;
   word_type match_len;

   modport source (output valid, mode, dest_pos, src_pos, match_len, input ready);
   modport sink   (input valid, mode, dest_pos, src_pos, match_len, output ready);
endinterface

interface mor_rsp_if;
   import mor_pkg::*;
   logic     valid;
   logic     ready;
   logic     is_final;
   word_type literal_start;
   word_type literal_count;
   word_type write_pos;
   word_type ref_offset;
   word_type extra_length;
   word_type matched_total;
   word_type overlap_total;

   modport source (output valid, is_final, literal_start, literal_count, write_pos,
                   ref_offset, extra_length, matched_total, overlap_total,
                   input ready);
   modport sink   (input valid, is_final, literal_start, literal_count, write_pos,
                   ref_offset, extra_length, matched_total, overlap_total,
                   output ready);
endinterface

// ----- src/mor_front.sv -----
// ----------------------------------------------------------------------------
// mor_front
// Accepts match beats, precomputes the match end and queues them.
// ----------------------------------------------------------------------------
module mor_front (
   input  logic              clock,
   input  logic              reset,
   mor_req_if.sink           req_chan,
   output mor_pkg::item_type head_item,
   output logic              head_valid,
   input  logic              head_pop
);
   import mor_pkg::*;

   item_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;
   item_type               new_item;

   assign req_chan.ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != '0);
   assign pop            = head_pop && head_valid;
   assign head_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.mode      = req_chan.mode;
      new_item.dest_pos  = req_chan.dest_pos;
      new_item.src_pos   = req_chan.src_pos;
      new_item.match_len = req_chan.match_len;
      // end of the match, unsaturated; trimming never moves it
      new_item.end_pos   = {1'b0, req_chan.dest_pos} + {1'b0, req_chan.match_len};
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- src/mor_back.sv -----
// ----------------------------------------------------------------------------
// mor_back
// Trims, keeps or drops queued matches against the running state.
// ----------------------------------------------------------------------------
module mor_back (
   input  logic              clock,
   input  logic              reset,
   input  mor_pkg::cfg_type  cfg,
   input  mor_pkg::item_type head_item,
   input  logic              head_valid,
   output logic              head_pop,
   mor_rsp_if.source         rsp_chan
);
   import mor_pkg::*;

   word_type   consumed_ff, consumed_in;
   word_type   compact_ff,  compact_in;
   word_type   kept_ff,     kept_in;
   word_type   dropped_ff,  dropped_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       advance;
   logic       take;
   wide_type   lit_diff;
   wide_type   rem_len;
   logic       trimmed;
   logic       covered;
   logic       short_len;
   logic       keep;
   word_type   overlap;
   word_type   kept_len;
   word_type   lit;
   word_type   drop_add;
   word_type   src_out;
   word_type   kept_next;
   word_type   dropped_next;
   logic [WORD_BITS+1:0] compact_sum;

   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign head_pop = advance;
   assign take     = advance && head_valid;

   always_comb begin
      lit_diff  = {1'b0, head_item.dest_pos} - {1'b0, consumed_ff};
      trimmed   = lit_diff[WORD_BITS];
      rem_len   = head_item.end_pos - {1'b0, consumed_ff};
      covered   = trimmed && (head_item.end_pos <= {1'b0, consumed_ff});
      overlap   = consumed_ff - head_item.dest_pos;
      kept_len  = trimmed ? rem_len[WORD_BITS-1:0] : head_item.match_len;
      short_len = (kept_len < cfg.min_len);
      keep      = !covered && !short_len;
      lit       = trimmed ? '0 : lit_diff[WORD_BITS-1:0];
      // a kept trimmed match drops only its overlap; any drop loses the whole length
      drop_add  = keep ? (trimmed ? overlap : '0) : head_item.match_len;
      src_out   = (trimmed && !cfg.rev_mode) ? head_item.src_pos + overlap
                                             : head_item.src_pos;
      kept_next    = sat_add_word(kept_ff, kept_len);
      dropped_next = sat_add_word(dropped_ff, drop_add);
      compact_sum  = {2'b00, compact_ff} + {2'b00, lit} + (WORD_BITS+2)'(1);
   end

   always_comb begin
      consumed_in  = consumed_ff;
      compact_in   = compact_ff;
      kept_in      = kept_ff;
      dropped_in   = dropped_ff;
      out_valid_in = advance ? 1'b0 : out_valid_ff;
      out_in       = out_ff;
      if (take) begin
         out_in.literal_start = consumed_ff;
         out_in.literal_count = lit;
         out_in.write_pos     = compact_ff;
         if (head_item.mode == MODE_END) begin
            out_valid_in         = 1'b1;
            out_in.is_final      = 1'b1;
            out_in.ref_offset    = '0;
            out_in.extra_length  = '0;
            out_in.matched_total = kept_ff;
            out_in.overlap_total = dropped_ff;
            consumed_in = '0;
            compact_in  = '0;
            kept_in     = '0;
            dropped_in  = '0;
         end else begin
            dropped_in = dropped_next;
            if (keep) begin
               out_valid_in         = 1'b1;
               out_in.is_final      = 1'b0;
               out_in.ref_offset    = src_out;
               out_in.extra_length  = kept_len - cfg.min_len;
               out_in.matched_total = kept_next;
               out_in.overlap_total = dropped_next;
               kept_in     = kept_next;
               consumed_in = (head_item.end_pos > POS_LIMIT) ?
                             POS_LIMIT[WORD_BITS-1:0] : head_item.end_pos[WORD_BITS-1:0];
               compact_in  = (compact_sum > {1'b0, POS_LIMIT}) ?
                             POS_LIMIT[WORD_BITS-1:0] : compact_sum[WORD_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         consumed_ff  <= '0;
         compact_ff   <= '0;
         kept_ff      <= '0;
         dropped_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         consumed_ff  <= consumed_in;
         compact_ff   <= compact_in;
         kept_ff      <= kept_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.is_final      = out_ff.is_final;
   assign rsp_chan.literal_start = out_ff.literal_start;
   assign rsp_chan.literal_count = out_ff.literal_count;
   assign rsp_chan.write_pos     = out_ff.write_pos;
   assign rsp_chan.ref_offset    = out_ff.ref_offset;
   assign rsp_chan.extra_length  = out_ff.extra_length;
   assign rsp_chan.matched_total = out_ff.matched_total;
   assign rsp_chan.overlap_total = out_ff.overlap_total;

endmodule

// ----- src/match_overlap_resolver_top.sv -----
// ----------------------------------------------------------------------------
// match_overlap_resolver_top
// Turns a sorted list of exact matches into compacted token records.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one beat per match (mode 0) or one end beat (mode 1,
//   dest_pos = text length). rsp_chan gives one beat per kept match and one
//   closing beat per end beat; covered or too-short matches give none.
//   csr_write_en/csr_index/csr_wdata set the minimum match length (index 0)
//   and reverse-complement mode (index 1); write them only while idle.
// Pipeline and throughput:
//   A request beat is held in the two-entry front queue, then the back stage
//   updates the running positions and registers the result. One beat per
//   cycle is sustained while rsp_chan is ready; the back stage updates its
//   state as it takes each beat.
// Reset:
//   Synchronous reset empties the queue, drops the output beat, clears the
//   positions and totals and restores the register defaults (32 and 1).
// Stall:
//   While rsp_chan stalls the result register holds, the back stage stops,
//   and the queue absorbs up to two more beats before req_chan.ready drops.
// ----------------------------------------------------------------------------
module match_overlap_resolver_top (
   input  logic                                   clock,
   input  logic                                   reset,
   mor_req_if.sink                                req_chan,
   mor_rsp_if.source                              rsp_chan,
   input  logic                                   csr_write_en,
   input  logic [mor_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mor_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import mor_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   // Configuration registers: decode the index, keep the rest.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_LEN:  cfg_in.min_len  = csr_wdata[WORD_BITS-1:0];
            CSR_REV_MODE: cfg_in.rev_mode = csr_wdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_len  <= MIN_LEN_RESET;
         cfg_ff.rev_mode <= REV_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept beats, precompute match end, queue them.
   mor_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Back: trim against the consumed position, emit or drop.
   mor_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- src/mor_checker.sv -----
// ----------------------------------------------------------------------------
// mor_checker
// Port-level checks of the resolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "match_overlap_resolver_top_assert.svh"

module mor_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_is_final,
   input mor_pkg::word_type rsp_literal_start,
   input mor_pkg::word_type rsp_write_pos,
   input mor_pkg::word_type rsp_ref_offset,
   input mor_pkg::word_type rsp_extra_length,
   input mor_pkg::word_type rsp_matched_total
);
   import mor_pkg::*;

   logic after_final_ff, after_final_in;

   // Set after reset or a closing beat; clear after any other beat.
   assign after_final_in = (rsp_valid && rsp_ready) ? rsp_is_final : after_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         after_final_ff <= 1'b1;
      end else begin
         after_final_ff <= after_final_in;
      end
   end

   `MOR_ASSERT_NR(a_reset_drops_beat, clock, reset |=> !rsp_valid, "result valid after reset")
   `MOR_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_final) && $stable(rsp_matched_total), "stalled result changed")
   `MOR_ASSERT(a_final_no_ref, clock, reset, rsp_valid && rsp_is_final |-> rsp_ref_offset == '0 && rsp_extra_length == '0, "closing beat carries a reference")
   `MOR_ASSERT(a_fresh_list_origin, clock, reset, rsp_valid && after_final_ff |-> rsp_literal_start == '0 && rsp_write_pos == '0, "first beat of a list not at origin")

endmodule

bind match_overlap_resolver_top mor_checker u_mor_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_is_final      (rsp_chan.is_final),
   .rsp_literal_start (rsp_chan.literal_start),
   .rsp_write_pos     (rsp_chan.write_pos),
   .rsp_ref_offset    (rsp_chan.ref_offset),
   .rsp_extra_length  (rsp_chan.extra_length),
   .rsp_matched_total (rsp_chan.matched_total)
);
